@@ hw/rtl/mpq_pkg.sv @@
package mpq_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 16;
  localparam int unsigned KEY_W            = 32;
  localparam int unsigned OCC_W            = 5;

  // Request operation codes.
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key_in;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } rsp_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_EXTRACT
  } cell_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                    valid;
    logic                    take;
    logic signed [KEY_W-1:0] key;
  } cell_link_t;

endpackage

@@ hw/rtl/mpq_cell.sv @@
module mpq_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  mpq_pkg::cell_cmd_t         cmd,
  input  logic signed [31:0]         key,
  input  mpq_pkg::cell_link_t        prev,
  input  mpq_pkg::cell_link_t        next,
  output mpq_pkg::cell_link_t        self
);
  import mpq_pkg::*;

  logic                    valid;
  logic                    valid_next;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] key_next;
  logic                    take;

  // The new key belongs at or before this cell when this cell is empty or smaller.
  assign take = !valid || (key > key_q);

  assign self.valid = valid;
  assign self.take  = take;
  assign self.key   = key_q;

  always_comb begin
    valid_next = valid;
    key_next   = key_q;
    unique case (cmd)
      CMD_INSERT: begin
        valid_next = valid | prev.valid;
        if (take) begin
          key_next = prev.take ? prev.key : key;
        end
      end
      CMD_EXTRACT: begin
        valid_next = next.valid;
        key_next   = next.key;
      end
      default: begin
        valid_next = valid;
        key_next   = key_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_next;
  end

endmodule

@@ hw/rtl/max_priority_queue.sv @@
// Channel   Ports               Handshake                      Payload
// request   start, busy, req    taken when start && !busy      op, key_in
// result    done, rsp           shown for one cycle on done    key_out, status, occupancy
//
// One request is taken per clock cycle; busy stays low, since every cell of the
// chain finishes its share of the update within the cycle that takes the request.
// The result appears on rsp with done high in the cycle right after the request.
// Synchronous reset empties the queue by clearing every cell's valid bit; no clearing pass is needed.
// The receiver cannot stall, so done never waits and nothing is buffered.
module max_priority_queue #(
  parameter int unsigned CAPACITY = mpq_pkg::CAPACITY_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mpq_pkg::req_t req,
  output logic          done,
  output mpq_pkg::rsp_t rsp
);
  import mpq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // The keys are held as a chain sorted from largest to smallest, with the
  // filled cells always forming a prefix. Cell 0 therefore holds the maximum.
  // An insert is broadcast to all cells: each cell decides whether the new key
  // lands at its slot, whether it takes the key of the cell before it (shifting
  // the tail down by one), or whether it keeps its own key. An extract makes
  // every cell take the key of the cell after it. Equal keys are identical
  // values, so the extracted sequence matches a heap ordering exactly.

  cell_link_t links [CAPACITY];
  cell_cmd_t  cmd;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  rsp_t          rsp_next;
  logic          accept;
  logic          is_full;
  logic          is_empty;

  localparam cell_link_t HEAD_LINK = '{valid: 1'b1, take: 1'b0, key: '0};
  localparam cell_link_t TAIL_LINK = '{valid: 1'b0, take: 1'b1, key: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t prev_link;
    cell_link_t next_link;

    if (i == 0) begin : g_head
      assign prev_link = HEAD_LINK;
    end else begin : g_prev
      assign prev_link = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_link = TAIL_LINK;
    end else begin : g_next
      assign next_link = links[i+1];
    end

    mpq_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .key  (req.key_in),
      .prev (prev_link),
      .next (next_link),
      .self (links[i])
    );
  end

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  // Decide what the chain does and what the result will say.
  always_comb begin
    cmd                = CMD_NONE;
    count_next         = count;
    rsp_next.key_out   = '0;
    rsp_next.status    = ST_OK;
    if (accept) begin
      priority if (req.op == OP_INSERT) begin
        if (is_full) begin
          rsp_next.status = ST_FULL;
        end else begin
          cmd        = CMD_INSERT;
          count_next = count + CW'(1);
        end
      end else begin
        if (is_empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          cmd              = CMD_EXTRACT;
          count_next       = count - CW'(1);
          rsp_next.key_out = links[0].key;
        end
      end
    end
    rsp_next.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  // The filled cells must always number exactly the count.
  logic [CAPACITY-1:0] valid_vec;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_valid
    assign valid_vec[i] = links[i].valid;
  end

  a_count_matches_cells : assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == count)
    else $error("filled cell count differs from occupancy count");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("occupancy count above capacity");

  a_result_follows_request : assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request taken without a result in the next cycle");

  a_full_only_at_capacity : assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> (count == CW'(CAPACITY)))
    else $error("full status reported below capacity");

  a_head_is_max : assert property (@(posedge clk) disable iff (rst)
    links[1].valid |-> !(links[1].key > links[0].key))
    else $error("second cell holds a larger key than the head");

endmodule
